FILE: rtl/aar_pkg.sv
// Shared types and constants for the argmax reduction block.
package aar_pkg;

    localparam int INNER_MAX = 4096;
    localparam int AXIS_MAX  = 65536;
    localparam int COL_W     = $clog2(INNER_MAX);
    localparam int POS_W     = $clog2(AXIS_MAX);
    localparam int KEY_W     = 64;

    localparam logic [1:0] TYPE_F32 = 2'd0;
    localparam logic [1:0] TYPE_I64 = 2'd1;
    localparam logic [1:0] TYPE_F16 = 2'd2;

    localparam logic [1:0] REG_ELEMENT_TYPE = 2'd0;
    localparam logic [1:0] REG_AXIS_LENGTH  = 2'd1;
    localparam logic [1:0] REG_INNER_COUNT  = 2'd2;

    // One element on its way through the read-modify-write pipe.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
        logic             ok;
        logic             first;
        logic             last;
        logic             slice_end;
    } t_elem;

    // Order-preserving key of a float pattern; -0 folds onto +0.
    function automatic logic [KEY_W-1:0] f32_key(input logic [31:0] b);
        logic [31:0] v;
        v = (b[30:0] == 31'd0) ? 32'd0 : b;
        if (v[31]) f32_key = {32'd0, ~v};
        else       f32_key = {32'd0, v | 32'h8000_0000};
    endfunction

    function automatic logic [KEY_W-1:0] f16_key(input logic [15:0] b);
        logic [15:0] v;
        v = (b[14:0] == 15'd0) ? 16'd0 : b;
        if (v[15]) f16_key = {48'd0, ~v};
        else       f16_key = {48'd0, v | 16'h8000};
    endfunction

endpackage

FILE: rtl/axis_argmax_reduction_top.sv
// Top level of the streaming argmax reduction along one tensor axis.
// o_valid rises once the last-position element word has gone through stage 1 and stage 2.
// Throughput: one element word per cycle unless the output stalls, set by one
// read-modify-write per cycle on the column entry memory, forwarding write to compare.
// Reset clears counters, configuration and the pipeline valids; the entry memory
// is not cleared, since every entry is written at axis position 0 before it is read.
module axis_argmax_reduction_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_element_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_max_index,
    output logic [11:0] o_column,
    output logic        o_slice_done
);
    import aar_pkg::*;

    logic [1:0]  r_type;
    logic [16:0] r_alen;
    logic [12:0] r_icnt;
    logic [COL_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_pos, n_pos;

    // Stage 1: element keyed, memory read in flight. Stage 2: compare and write.
    logic  r_v1;
    t_elem r_e1;
    logic  r_ov;
    logic [15:0] r_oidx;
    logic [11:0] r_ocol;
    logic  r_odone;

    logic        acc;
    logic        adv;
    logic [16:0] alen_eff;
    logic [13:0] icnt_eff;
    logic [KEY_W-1:0] key_in;
    logic        ok_in;
    logic [KEY_W-1:0] low_key;
    logic        last_in;
    logic        slice_in;
    t_elem       e_in;

    logic [KEY_W+POS_W-1:0] rd;
    logic        r_fw_v;
    logic [COL_W-1:0] r_fw_col;
    logic [KEY_W+POS_W-1:0] r_fw_data;
    logic [KEY_W-1:0] cur_key;
    logic [POS_W-1:0] cur_pos;
    logic        we;
    logic [KEY_W-1:0] w_key;
    logic [POS_W-1:0] w_pos;

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;
    assign acc     = i_valid && o_ready;

    always_comb begin
        alen_eff = (r_alen == 17'd0) ? 17'd1 :
                   (r_alen > 17'(AXIS_MAX)) ? 17'(AXIS_MAX) : r_alen;
        icnt_eff = (r_icnt == 13'd0) ? 14'd1 :
                   ({1'b0, r_icnt} > 14'(INNER_MAX)) ? 14'(INNER_MAX) : {1'b0, r_icnt};
    end

    always_comb begin
        ok_in = 1'b1;
        case (r_type)
            TYPE_F32: begin
                key_in  = f32_key(i_element_bits[31:0]);
                ok_in   = !(i_element_bits[30:23] == 8'hFF && i_element_bits[22:0] != 23'd0);
                low_key = f32_key(32'hFF7F_FFFF);
            end
            TYPE_F16: begin
                key_in  = f16_key(i_element_bits[15:0]);
                ok_in   = !(i_element_bits[14:10] == 5'h1F && i_element_bits[9:0] != 10'd0);
                low_key = f16_key(16'hFBFF);
            end
            default: begin
                key_in  = i_element_bits ^ 64'h8000_0000_0000_0000;
                low_key = '0;
            end
        endcase
    end

    always_comb begin
        last_in  = {1'b0, r_pos} >= (alen_eff - 17'd1);
        slice_in = ({2'b0, r_col} + 14'd1) >= icnt_eff;
        n_col = r_col + 1'b1;
        n_pos = r_pos;
        if (slice_in) begin
            n_col = '0;
            n_pos = last_in ? '0 : r_pos + 1'b1;
        end
        e_in.col       = r_col;
        e_in.pos       = r_pos;
        e_in.ok        = ok_in;
        e_in.first     = (r_pos == '0);
        e_in.last      = last_in;
        e_in.slice_end = slice_in;
        e_in.key       = (r_pos == '0) ? ((ok_in && key_in > low_key) ? key_in : low_key)
                                       : key_in;
    end

    // Forward the entry written when the same column was read back; the
    // forwarded copy is held while the compare stage waits on the output.
    always_comb begin
        if (r_fw_v && r_fw_col == r_e1.col) begin
            cur_key = r_fw_data[KEY_W+POS_W-1:POS_W];
            cur_pos = r_fw_data[POS_W-1:0];
        end else begin
            cur_key = rd[KEY_W+POS_W-1:POS_W];
            cur_pos = rd[POS_W-1:0];
        end
        we    = 1'b0;
        w_key = r_e1.key;
        w_pos = r_e1.pos;
        if (r_e1.first) begin
            we    = 1'b1;
            w_pos = '0;
        end else if (r_e1.ok && r_e1.key > cur_key) begin
            we = 1'b1;
        end
        we = we && r_v1 && adv;
    end

    aar_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_e1.col),
        .i_wdata ({w_key, w_pos}),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TYPE_F32;
            r_alen <= 17'd1;
            r_icnt <= 13'd1;
            r_col  <= '0;
            r_pos  <= '0;
            r_v1   <= 1'b0;
            r_ov   <= 1'b0;
            r_fw_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ELEMENT_TYPE: r_type <= i_cfg_data[1:0];
                    REG_AXIS_LENGTH:  r_alen <= i_cfg_data;
                    REG_INNER_COUNT:  r_icnt <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (acc) begin
                r_col <= n_col;
                r_pos <= n_pos;
            end
            if (adv) begin
                r_v1   <= acc;
                r_ov   <= r_v1 && r_e1.last;
                r_fw_v <= we;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_fw_data <= {w_key, w_pos};
        if (we) r_fw_col  <= r_e1.col;
        if (acc) r_e1 <= e_in;
        if (adv) begin
            r_oidx  <= we ? w_pos : cur_pos;
            r_ocol  <= r_e1.col;
            r_odone <= r_e1.slice_end;
        end
    end

    assign o_valid      = r_ov;
    assign o_max_index  = r_oidx;
    assign o_column     = r_ocol;
    assign o_slice_done = r_odone;
endmodule

FILE: rtl/aar_entry_ram.sv
// Column entry memory: running key and best position, with a registered read.
module aar_entry_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [aar_pkg::COL_W-1:0] i_waddr,
    input  logic [aar_pkg::KEY_W+aar_pkg::POS_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [aar_pkg::COL_W-1:0] i_raddr,
    output logic [aar_pkg::KEY_W+aar_pkg::POS_W-1:0] o_rdata
);
    import aar_pkg::*;

    logic [KEY_W+POS_W-1:0] r_mem [INNER_MAX];
    logic [KEY_W+POS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/aar_checker.sv
// Port-level checker for the argmax reduction block, bound to the top level.
module aar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_max_index,
    input logic [11:0] o_column
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_max_index) && $stable(o_column))
        else $error("result word changed while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word right after reset");

    // Idle input with an empty output, in this cycle and the one before, leaves nothing that could emit.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !(i_valid && o_ready) ##1 !o_valid && !(i_valid && o_ready)
        |=> !o_valid)
        else $error("result word without an element word");
endmodule

bind axis_argmax_reduction_top aar_checker u_aar_checker (.*);

FILE: bench/tb_axis_argmax_reduction_top.sv
// Self-checking testbench for the streaming argmax reduction top level.
module tb_axis_argmax_reduction_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aar_pkg::*;

    typedef struct {
        logic [15:0] max_index;
        logic [11:0] column;
        logic        slice_done;
    } t_argmax_result;

    class argmax_scoreboard;
        logic [1:0]     elem_type;
        int unsigned    axis_len;
        int unsigned    col_count;
        logic [63:0]    best_key [INNER_MAX];
        logic [15:0]    best_pos [INNER_MAX];
        int unsigned    col_cnt;
        int unsigned    axis_cnt;
        int unsigned    cols_written;
        int unsigned    fail_count;
        t_argmax_result pending[$];

        function new();
            elem_type    = TYPE_F32;
            axis_len     = 1;
            col_count    = 1;
            col_cnt      = 0;
            axis_cnt     = 0;
            cols_written = 0;
            fail_count   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [16:0] value);
            case (index)
                REG_ELEMENT_TYPE: elem_type = value[1:0];
                REG_AXIS_LENGTH:  axis_len  = value;
                REG_INNER_COUNT:  col_count = value[12:0];
                default: ;
            endcase
        endfunction

        // Order-preserving key; -0 folds onto +0.
        function logic [63:0] float_order(logic [63:0] b, int sbit);
            logic [63:0] msb;
            logic [63:0] full;
            msb  = 64'd1 << sbit;
            full = msb | (msb - 64'd1);
            b    = b & full;
            if ((b & (msb - 64'd1)) == 64'd0) b = 64'd0;
            return (b & msb) != 0 ? (~b & full) : (b | msb);
        endfunction

        function logic [63:0] order_key(logic [63:0] bits, output bit is_num);
            is_num = 1'b1;
            case (elem_type)
                TYPE_F32: begin
                    is_num = !(bits[30:23] == 8'hFF && bits[22:0] != 0);
                    return float_order({32'd0, bits[31:0]}, 31);
                end
                TYPE_F16: begin
                    is_num = !(bits[14:10] == 5'h1F && bits[9:0] != 0);
                    return float_order({48'd0, bits[15:0]}, 15);
                end
                default: return bits ^ 64'h8000_0000_0000_0000;
            endcase
        endfunction

        function logic [63:0] lowest_order();
            case (elem_type)
                TYPE_F32: return float_order(64'hFF7F_FFFF, 31);
                TYPE_F16: return float_order(64'hFBFF, 15);
                default:  return 64'd0;
            endcase
        endfunction

        function void note_element(logic [63:0] bits);
            int unsigned    alen;
            int unsigned    ncol;
            int unsigned    c;
            int unsigned    p;
            logic [63:0]    k;
            logic [63:0]    low;
            bit             is_num;
            t_argmax_result r;
            alen = axis_len == 0 ? 1 : (axis_len > AXIS_MAX ? AXIS_MAX : axis_len);
            ncol = col_count == 0 ? 1 : (col_count > INNER_MAX ? INNER_MAX : col_count);
            c = col_cnt % INNER_MAX;
            p = axis_cnt;
            k = order_key(bits, is_num);
            if (p == 0) begin
                low = lowest_order();
                best_key[c] = (is_num && k > low) ? k : low;
                best_pos[c] = 16'd0;
                if (c + 1 > cols_written) cols_written = c + 1;
            end else if (is_num && k > best_key[c]) begin
                best_key[c] = k;
                best_pos[c] = p[15:0];
            end
            if (p >= alen - 1) begin
                r.max_index  = best_pos[c];
                r.column     = c[11:0];
                r.slice_done = (c + 1 >= ncol);
                pending.push_back(r);
            end
            c++;
            if (c >= ncol) begin
                c = 0;
                p++;
                if (p >= alen) p = 0;
            end
            col_cnt  = c;
            axis_cnt = p;
        endfunction

        function void check_result(logic [15:0] idx, logic [11:0] col, logic done);
            t_argmax_result e;
            if (pending.size() == 0) begin
                $error("unexpected result word: max_index %0d column %0d", idx, col);
                fail_count++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.max_index) begin
                $error("max_index: expected %0d, got %0d", e.max_index, idx);
                fail_count++;
            end
            if (col !== e.column) begin
                $error("column: expected %0d, got %0d", e.column, col);
                fail_count++;
            end
            if (done !== e.slice_done) begin
                $error("slice_done: expected %0b, got %0b", e.slice_done, done);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_ELEMENT_TYPE;
    logic [16:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_element_bits = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_max_index;
    logic [11:0] o_column;
    logic        o_slice_done;

    argmax_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    axis_argmax_reduction_top dut (.*);

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_max_index, o_column, o_slice_done);
    end

    initial begin
        #20ms;
        $display("axis_argmax_reduction_top test failed");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_word(input logic [63:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_element_bits <= bits;
        do @(posedge i_clk); while (!o_ready);
        sb.note_element(bits);
        @(negedge i_clk);
    endtask

    // Waits for every expected word, then for the pipe to empty of silent words.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] et, input logic [16:0] alen,
                              input logic [12:0] ncol);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ELEMENT_TYPE;
        i_cfg_data  <= {15'd0, et};
        sb.write_reg(REG_ELEMENT_TYPE, {15'd0, et});
        @(negedge i_clk);
        i_cfg_index <= REG_AXIS_LENGTH;
        i_cfg_data  <= alen;
        sb.write_reg(REG_AXIS_LENGTH, alen);
        @(negedge i_clk);
        i_cfg_index <= REG_INNER_COUNT;
        i_cfg_data  <= {4'd0, ncol};
        sb.write_reg(REG_INNER_COUNT, {4'd0, ncol});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] random_element(logic [1:0] et);
        logic [63:0] r;
        logic        s;
        r = {$urandom, $urandom};
        s = 1'($urandom_range(1));
        case ($urandom_range(9))
            4: r = (et == TYPE_F32) ? {r[63:32], 32'h3F80_0000 | (r[1:0] << 20)} :
                   (et == TYPE_F16) ? {r[63:16], 16'h3C00 | (r[1:0] << 8)} :
                                      64'(signed'(r[2:0]) - 3);
            5: r = (et == TYPE_F32) ? {r[63:32], s, 8'hFF, 1'b1, r[21:0]} :
                   (et == TYPE_F16) ? {r[63:16], s, 5'h1F, 1'b1, r[8:0]} : 64'd0;
            6: r = (et == TYPE_F32) ? {r[63:32], s, 31'h7F80_0000} :
                   (et == TYPE_F16) ? {r[63:16], s, 15'h7C00} : {s, {63{~s}}};
            7: r = (et == TYPE_F32) ? {r[63:32], s, 31'd0} :
                   (et == TYPE_F16) ? {r[63:16], s, 15'd0} : {64{s}};
            8: r = (et == TYPE_F32) ? {r[63:32], s, 31'h7F7F_FFFF} :
                   (et == TYPE_F16) ? {r[63:16], s, 15'h7BFF} : {~s, {63{s}}};
            9: r = (et == TYPE_F32) ? {r[63:32], r[31], 8'h80, r[22:0]} :
                   (et == TYPE_F16) ? {r[63:16], r[15], 5'h10, r[9:0]} :
                                      {{56{r[7]}}, r[7:0]};
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        int unsigned phase;
        int unsigned n;
        logic [1:0]  et;
        logic [16:0] alen;
        logic [12:0] ncol;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: float32, one element per slice.
        send_word(64'h0000_0000_8000_0000);
        send_word(64'hFFFF_FFFF_7FC0_0001);
        send_word(64'h0000_0000_FF80_0000);
        send_word(64'h0000_0000_FF7F_FFFF);
        drain();
        // Ties keep the first position; NaN is skipped; -0 equals +0.
        set_config(TYPE_F32, 17'd4, 13'd2);
        send_word(64'h8000_0000);  send_word(64'h7FC0_0000);
        send_word(64'h0000_0000);  send_word(64'h7F80_0000);
        send_word(64'h3F80_0000);  send_word(64'h7F80_0000);
        send_word(64'h7F80_0001);  send_word(64'hFF80_0000);
        drain();
        set_config(TYPE_I64, 17'd3, 13'd1);
        send_word(64'h8000_0000_0000_0000);
        send_word(64'h7FFF_FFFF_FFFF_FFFF);
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        // Float16 with junk in the ignored upper bits; unused code acts as int64.
        set_config(TYPE_F16, 17'd3, 13'd1);
        send_word(64'hFFFF_FFFF_FFFF_FBFF);
        send_word(64'hA5A5_A5A5_A5A5_7C01);
        send_word(64'h1234_5678_9ABC_FC00);
        drain();
        set_config(2'd3, 17'd0, 13'd0);
        send_word(64'h0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        // Column count above the limit clamps to the full memory: no slice end yet.
        set_config(TYPE_F32, 17'd1, 13'h1FFF);
        for (int i = 0; i < 40; i++) send_word(random_element(TYPE_F32));
        drain();
        // Axis length above the limit clamps to the full position range: no result yet.
        set_config(TYPE_I64, 17'h1FFFF, 13'd1);
        for (int i = 0; i < 150; i++) send_word(random_element(TYPE_I64));
        drain();

        // Random phases; counters carry across phases, so some reconfigure mid-slice.
        for (phase = 0; phase < 20; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            et   = 2'($urandom_range(3));
            alen = ($urandom_range(9) == 0) ? 17'd0 : 17'($urandom_range(1, 7));
            ncol = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
            // A wider slice mid-axis would read columns never written.
            if (sb.axis_cnt != 0 && ncol > sb.cols_written) ncol = 13'(sb.cols_written);
            set_config(et, alen, ncol);
            n = $urandom_range(20, 55);
            for (int i = 0; i < n; i++) send_word(random_element(et));
            drain();
        end

        if (sb.fail_count == 0 && sb.pending.size() == 0) begin
            $display("axis_argmax_reduction_top test passed");
        end else begin
            $display("axis_argmax_reduction_top test failed");
        end
        $finish;
    end

endmodule
